FILE: src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the polyphonic voice allocator
// Holds the input and result word formats, the per-voice state entry, the
// command and action codes and the sequencer states.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int VOICE_W    = 3;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int AGE_W      = 32;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_IDLE     = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_TRIGGER    = 3'd0,
    ACT_STEAL      = 3'd1,
    ACT_RELEASE    = 3'd2,
    ACT_CANCEL     = 3'd3,
    ACT_REL_CANCEL = 3'd4,
    ACT_FREE       = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
    logic [VOICE_W-1:0] idle_voice;
  } in_word_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [2:0]         action;
    logic [NOTE_W-1:0]  out_note;
    logic [VEL_W-1:0]   out_velocity;
    logic               last;
  } out_word_t;

  // State of one voice as kept in the voice memory.
  typedef struct packed {
    logic              active;
    logic              releasing;
    logic [NOTE_W-1:0] note;
    logic [AGE_W-1:0]  age;
    logic              pend_valid;
    logic [NOTE_W-1:0] pend_note;
    logic [VEL_W-1:0]  pend_vel;
  } entry_t;

endpackage

FILE: src/pva_voice_ram.sv
// ----------------------------------------------------------------------------
// pva_voice_ram: per-voice state memory
// One write port and one read port with registered read data. A valid bit
// per entry makes entries that were never written read as all zero.
// ----------------------------------------------------------------------------
module pva_voice_ram
  import pva_pkg::*;
#(
  parameter int DEPTH = VOICES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t             mem_r [DEPTH];
  entry_t             rd_q_r;
  logic               rd_ok_r;
  logic [DEPTH-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

FILE: src/poly_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator_core: polyphonic voice allocator with oldest-voice steal
// Maps note on, note off and envelope-idle events onto synth voices and
// reports, per event, the list of voice actions in ascending voice order.
// ----------------------------------------------------------------------------
// One event is handled at a time. The per-voice state sits in a memory with
// one read and one write port, so the sequencer walks the voices one per
// cycle while the output register does not stall it, with one read per
// voice. A note off scans all voices; a note on scans all voices and then
// writes the chosen voice in a step of its own. An idle event reads only
// the named voice. Unused commands and idle events naming a voice beyond
// the pool go straight to the flush without a scan.
// Each result word is delivered once the output register is free. A full
// output register stalls the voice scan or the final flush, never the
// results already made.
// The last word of an event carries last = 1; an event that acts on no voice
// gives no word at all. The voice field is the low three bits of the voice
// index. The trigger counter saturates at its maximum value. A new event is
// taken while the final result of the previous one still waits at the output.
// ----------------------------------------------------------------------------
module poly_voice_allocator_core
  import pva_pkg::*;
#(
  parameter int VOICES = VOICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Voice index width and a scan counter wide enough to hold VOICES itself.
  localparam int VW  = $clog2(VOICES);
  localparam int VCW = $clog2(VOICES + 1);

  state_t            state_r, state_nxt;
  logic [1:0]        cmd_r, cmd_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [VEL_W-1:0]  vel_r, vel_nxt;

  // Scan control: next address to read, end of the range, and the entry
  // whose read data is present this cycle.
  logic [VCW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [VCW-1:0]    end_r, end_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  logic [VW-1:0]     ev_idx_r, ev_idx_nxt;

  // Note-on candidates gathered during the scan.
  logic              have_inact_r, have_inact_nxt;
  logic [VW-1:0]     inact_idx_r, inact_idx_nxt;
  logic              have_rel_r, have_rel_nxt;
  logic [VW-1:0]     rel_idx_r, rel_idx_nxt;
  logic [NOTE_W-1:0] rel_note_r, rel_note_nxt;
  logic [VW-1:0]     best_idx_r, best_idx_nxt;
  logic [AGE_W-1:0]  best_age_r, best_age_nxt;
  logic [NOTE_W-1:0] best_note_r, best_note_nxt;

  logic [AGE_W-1:0]  tc_r, tc_nxt;

  // The newest result is held back one step so that the final one of an
  // event can be marked with last.
  logic              held_vld_r, held_vld_nxt;
  out_word_t         held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // Voice memory ports.
  logic              rd_en;
  logic [VW-1:0]     rd_addr;
  entry_t            ent;
  logic              wr_en;
  logic [VW-1:0]     wr_addr;
  entry_t            wr_data;

  // Evaluation of the entry present this cycle.
  logic              ev_rel, ev_can;
  logic              emit_vld;
  out_word_t         emit_w;
  logic              wr_req;
  entry_t            wr_ent;
  logic              out_free;
  logic              adv;
  logic              iv_ok;
  logic [VW-1:0]     ch_idx;
  logic              ch_busy;
  logic [NOTE_W-1:0] ch_note;

  pva_voice_ram #(
    .DEPTH (VOICES)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Result and write-back for the entry whose read data is present.
  always_comb begin
    ev_rel   = ent.active && (ent.note == note_r);
    ev_can   = ent.pend_valid && (ent.pend_note == note_r);
    emit_vld = 1'b0;
    emit_w   = '0;
    emit_w.voice = VOICE_W'(ev_idx_r);
    wr_req   = 1'b0;
    wr_ent   = ent;
    case (cmd_r)
      CMD_NOTE_OFF: begin
        if (ev_rel || ev_can) begin
          emit_vld = 1'b1;
          wr_req   = 1'b1;
          if (ev_rel) begin
            wr_ent.releasing = 1'b1;
          end
          if (ev_can) begin
            wr_ent.pend_valid = 1'b0;
          end
          if (ev_rel && ev_can) begin
            emit_w.action = ACT_REL_CANCEL;
          end else if (ev_rel) begin
            emit_w.action = ACT_RELEASE;
          end else begin
            emit_w.action = ACT_CANCEL;
          end
        end
      end
      CMD_IDLE: begin
        if (ent.active) begin
          emit_vld = 1'b1;
          wr_req   = 1'b1;
          wr_ent.releasing = 1'b0;
          if (ent.pend_valid) begin
            // Fire the waiting note on this voice; its stamp stays.
            wr_ent.note       = ent.pend_note;
            wr_ent.pend_valid = 1'b0;
            emit_w.action       = ACT_TRIGGER;
            emit_w.out_note     = ent.pend_note;
            emit_w.out_velocity = ent.pend_vel;
          end else begin
            wr_ent.active = 1'b0;
            emit_w.action = ACT_FREE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  // A new result needs the held one moved to the output register first.
  assign adv      = !(ev_vld_r && emit_vld && held_vld_r && !out_free);
  assign iv_ok    = ({{(32 - VOICE_W){1'b0}}, in_word.idle_voice} < 32'(VOICES));

  // Voice chosen for a note on: first inactive, else first releasing,
  // else the oldest trigger stamp.
  always_comb begin
    if (have_inact_r) begin
      ch_idx  = inact_idx_r;
      ch_busy = 1'b0;
      ch_note = note_r;
    end else if (have_rel_r) begin
      ch_idx  = rel_idx_r;
      ch_busy = 1'b1;
      ch_note = rel_note_r;
    end else begin
      ch_idx  = best_idx_r;
      ch_busy = 1'b1;
      ch_note = best_note_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    note_nxt       = note_r;
    vel_nxt        = vel_r;
    rd_idx_nxt     = rd_idx_r;
    end_nxt        = end_r;
    ev_vld_nxt     = ev_vld_r;
    ev_idx_nxt     = ev_idx_r;
    have_inact_nxt = have_inact_r;
    inact_idx_nxt  = inact_idx_r;
    have_rel_nxt   = have_rel_r;
    rel_idx_nxt    = rel_idx_r;
    rel_note_nxt   = rel_note_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    best_note_nxt  = best_note_r;
    tc_nxt         = tc_r;
    held_vld_nxt   = held_vld_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[VW-1:0];
    wr_en          = 1'b0;
    wr_addr        = ev_idx_r;
    wr_data        = wr_ent;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_word.cmd;
          note_nxt       = in_word.note;
          vel_nxt        = in_word.velocity;
          ev_vld_nxt     = 1'b0;
          have_inact_nxt = 1'b0;
          have_rel_nxt   = 1'b0;
          rd_idx_nxt     = '0;
          end_nxt        = VCW'(VOICES);
          state_nxt      = ST_SCAN;
          case (in_word.cmd)
            CMD_NOTE_ON, CMD_NOTE_OFF: begin
            end
            CMD_IDLE: begin
              if (iv_ok) begin
                rd_idx_nxt = VCW'(in_word.idle_voice);
                end_nxt    = VCW'(in_word.idle_voice) + VCW'(1);
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
            default: begin
              state_nxt = ST_FLUSH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (adv) begin
          if (ev_vld_r) begin
            wr_en = wr_req;
            if (emit_vld) begin
              if (held_vld_r) begin
                out_valid_nxt = 1'b1;
                out_word_nxt  = held_r;
              end
              held_vld_nxt = 1'b1;
              held_nxt     = emit_w;
            end
            if (cmd_r == CMD_NOTE_ON) begin
              if (!ent.active && !have_inact_r) begin
                have_inact_nxt = 1'b1;
                inact_idx_nxt  = ev_idx_r;
              end
              if (ent.releasing && !have_rel_r) begin
                have_rel_nxt = 1'b1;
                rel_idx_nxt  = ev_idx_r;
                rel_note_nxt = ent.note;
              end
              if ((ev_idx_r == '0) || (ent.age < best_age_r)) begin
                best_idx_nxt  = ev_idx_r;
                best_age_nxt  = ent.age;
                best_note_nxt = ent.note;
              end
            end
          end
          if (rd_idx_r != end_r) begin
            rd_en      = 1'b1;
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_idx_r[VW-1:0];
            rd_idx_nxt = rd_idx_r + VCW'(1);
          end else begin
            ev_vld_nxt = 1'b0;
            state_nxt  = (cmd_r == CMD_NOTE_ON) ? ST_WRITE : ST_FLUSH;
          end
        end
      end

      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = ch_idx;
        wr_data = '0;
        wr_data.active = 1'b1;
        wr_data.age    = tc_r;
        if (ch_busy) begin
          // Steal: the voice keeps sounding its note while it releases.
          wr_data.releasing  = 1'b1;
          wr_data.note       = ch_note;
          wr_data.pend_valid = 1'b1;
          wr_data.pend_note  = note_r;
          wr_data.pend_vel   = vel_r;
        end else begin
          wr_data.note = note_r;
        end
        held_vld_nxt          = 1'b1;
        held_nxt.voice        = VOICE_W'(ch_idx);
        held_nxt.action       = ch_busy ? ACT_STEAL : ACT_TRIGGER;
        held_nxt.out_note     = note_r;
        held_nxt.out_velocity = vel_r;
        held_nxt.last         = 1'b0;
        if (tc_r != '1) begin
          tc_nxt = tc_r + AGE_W'(1);
        end
        state_nxt = ST_FLUSH;
      end

      ST_FLUSH: begin
        if (!held_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_word_nxt      = held_r;
          out_word_nxt.last = 1'b1;
          held_vld_nxt      = 1'b0;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ev_vld_r     <= 1'b0;
      have_inact_r <= 1'b0;
      have_rel_r   <= 1'b0;
      tc_r         <= '0;
      held_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ev_vld_r     <= ev_vld_nxt;
      have_inact_r <= have_inact_nxt;
      have_rel_r   <= have_rel_nxt;
      tc_r         <= tc_nxt;
      held_vld_r   <= held_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    note_r      <= note_nxt;
    vel_r       <= vel_nxt;
    rd_idx_r    <= rd_idx_nxt;
    end_r       <= end_nxt;
    ev_idx_r    <= ev_idx_nxt;
    inact_idx_r <= inact_idx_nxt;
    rel_idx_r   <= rel_idx_nxt;
    rel_note_r  <= rel_note_nxt;
    best_idx_r  <= best_idx_nxt;
    best_age_r  <= best_age_nxt;
    best_note_r <= best_note_nxt;
    held_r      <= held_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // Nothing may stay held back once the block is ready for a new event.
  a_held_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !held_vld_r)
    else $error("result still held while idle");

  // The scan never reads the entry it writes in the same cycle.
  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("read and write of the same voice entry");

  // Read data is only pending during a scan.
  a_ev_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_SCAN |-> !ev_vld_r)
    else $error("voice read pending outside scan");

  // The trigger stamp never goes backwards.
  a_tc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> tc_r >= $past(tc_r))
    else $error("trigger counter decreased");
`endif

endmodule
